@@ rtl/core/assert_macros.svh @@
// assertion helpers shared by the rtl, clocked on clk and held off during arst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TCN_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TCN_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/tcn_pkg.sv @@
package tcn_pkg;
	localparam int HEIGHT_BITS = 16;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int SPACING_BITS = 8;
	localparam logic [SPACING_BITS-1:0] SPACING_RESET = 8'd8;
	// reduced component magnitudes are kept below 2^MAG_CAP_BITS
	localparam int MAG_CAP_BITS = 31;
endpackage

@@ rtl/core/tcn_if.sv @@
interface tcn_cell_if #(
	parameter int HEIGHT_BITS = tcn_pkg::HEIGHT_BITS
);
	logic valid;
	logic ready;
	logic signed [HEIGHT_BITS-1:0] height_top_left;
	logic signed [HEIGHT_BITS-1:0] height_top_right;
	logic signed [HEIGHT_BITS-1:0] height_bottom_left;
	logic signed [HEIGHT_BITS-1:0] height_bottom_right;

	modport source (
		output valid, height_top_left, height_top_right, height_bottom_left,
			height_bottom_right,
		input ready
	);
	modport sink (
		input valid, height_top_left, height_top_right, height_bottom_left,
			height_bottom_right,
		output ready
	);
endinterface

interface tcn_norm_if #(
	parameter int HEIGHT_BITS = tcn_pkg::HEIGHT_BITS,
	parameter int NORMAL_FRAC_BITS = tcn_pkg::NORMAL_FRAC_BITS
);
	logic valid;
	logic ready;
	logic signed [HEIGHT_BITS-1:0] center_height;
	logic signed [NORMAL_FRAC_BITS+1:0] upper_normal_x;
	logic [NORMAL_FRAC_BITS:0] upper_normal_y;
	logic signed [NORMAL_FRAC_BITS+1:0] upper_normal_z;
	logic signed [NORMAL_FRAC_BITS+1:0] lower_normal_x;
	logic [NORMAL_FRAC_BITS:0] lower_normal_y;
	logic signed [NORMAL_FRAC_BITS+1:0] lower_normal_z;

	modport source (
		output valid, center_height, upper_normal_x, upper_normal_y, upper_normal_z,
			lower_normal_x, lower_normal_y, lower_normal_z,
		input ready
	);
	modport sink (
		input valid, center_height, upper_normal_x, upper_normal_y, upper_normal_z,
			lower_normal_x, lower_normal_y, lower_normal_z,
		output ready
	);
endinterface

@@ rtl/core/terrain_cell_normals_unit.sv @@
// Terrain cell normals: takes one cell (four corner heights) per clock and returns the
// floor-rounded center height and the unit normals of the upper-left and lower-right
// triangles in Q1.NORMAL_FRAC_BITS (x and z signed, y unsigned), rounded to nearest with
// ties away from zero. Throughput is one cell per clock while the output is not stalled.
// The restoring divider yields one quotient bit per stage (2*NORMAL_FRAC_BITS+3 stages)
// and the square root that follows it one root bit per stage (NORMAL_FRAC_BITS+2 stages).
// Every stage holds its word and refills as soon as the stage after it moves, so bubbles
// are squeezed out under output back-pressure.
// A zero grid spacing gives the upright normal for both triangles.
`include "assert_macros.svh"

module terrain_cell_normals_unit #(
	parameter int HEIGHT_BITS = tcn_pkg::HEIGHT_BITS,
	parameter int NORMAL_FRAC_BITS = tcn_pkg::NORMAL_FRAC_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [tcn_pkg::SPACING_BITS-1:0] cfg_wdata,
	tcn_cell_if.sink cells,
	tcn_norm_if.source normals
);
	import tcn_pkg::*;

	localparam int HB = HEIGHT_BITS;
	localparam int F = NORMAL_FRAC_BITS;
	localparam int SB = SPACING_BITS;
	localparam int DW = HB + 1;
	localparam int MW = (HB > MAG_CAP_BITS) ? MAG_CAP_BITS : HB;
	localparam int CW = 2 * MW;
	localparam int NW = 2 * MW + 2;
	localparam int QW = 2 * F + 3;
	localparam int RW = F + 2;
	localparam int TW = 2 * RW + 1;
	localparam int ST_DIV0 = 4;
	localparam int ST_SQ0 = ST_DIV0 + QW;
	localparam int ST_OUT = ST_SQ0 + RW;
	localparam int L = ST_OUT + 1;
	localparam logic [F:0] Y_ONE = (F+1)'(1) << F;

	typedef struct packed {
		logic up;
		logic [1:0] nx;
		logic [1:0] nz;
		logic [HB-1:0] ctr;
	} carry_t;

	logic [SB-1:0] spacing_q;
	logic [L-1:0] vld_s;
	logic [L-1:0] adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= SPACING_RESET;
		end else if (cfg_we) begin
			spacing_q <= cfg_wdata;
		end
	end

	// a stage moves when it is empty or the stage after it moves
	assign adv[L-1] = !vld_s[L-1] || normals.ready;
	for (genvar i = 0; i < L-1; i++) begin : g_adv
		assign adv[i] = !vld_s[i] || adv[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv[0]) begin
			vld_s[0] <= cells.valid;
		end
	end
	for (genvar i = 1; i < L; i++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv[i]) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	assign cells.ready = adv[0];

	// stage 1: corner differences and corner sum
	logic signed [DW-1:0] h00_w, h10_w, h01_w, h11_w;
	logic signed [DW-1:0] dx_s1 [2];
	logic signed [DW-1:0] dz_s1 [2];
	logic signed [HB+1:0] sum_s1;
	logic [SB-1:0] sp_s1;

	assign h00_w = {cells.height_top_left[HB-1], cells.height_top_left};
	assign h10_w = {cells.height_top_right[HB-1], cells.height_top_right};
	assign h01_w = {cells.height_bottom_left[HB-1], cells.height_bottom_left};
	assign h11_w = {cells.height_bottom_right[HB-1], cells.height_bottom_right};

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			dx_s1[0] <= h00_w - h10_w;
			dz_s1[0] <= h00_w - h01_w;
			dx_s1[1] <= h01_w - h11_w;
			dz_s1[1] <= h10_w - h11_w;
			sum_s1 <= (HB+2)'(h00_w) + (HB+2)'(h10_w) + (HB+2)'(h01_w) + (HB+2)'(h11_w);
			sp_s1 <= spacing_q;
		end
	end

	// stage 2: magnitudes, signs, range reduction
	logic [HB-1:0] axf_w [2];
	logic [HB-1:0] azf_w [2];
	logic [DW-1:0] negx_w [2];
	logic [DW-1:0] negz_w [2];
	logic [MW-1:0] ax_w [2];
	logic [MW-1:0] az_w [2];
	logic [SB-1:0] sp_w [2];
	logic [MW-1:0] ax_s2 [2];
	logic [MW-1:0] az_s2 [2];
	logic [SB-1:0] sp_s2 [2];
	carry_t car_s2;

	for (genvar t = 0; t < 2; t++) begin : g_mag
		assign negx_w[t] = -dx_s1[t];
		assign negz_w[t] = -dz_s1[t];
		assign axf_w[t] = dx_s1[t][DW-1] ? negx_w[t][HB-1:0] : dx_s1[t][HB-1:0];
		assign azf_w[t] = dz_s1[t][DW-1] ? negz_w[t][HB-1:0] : dz_s1[t][HB-1:0];
		if (HB > MW) begin : g_red
			logic big;
			// wide heights: halve the whole vector once
			assign big = (|axf_w[t][HB-1:MW]) || (|azf_w[t][HB-1:MW]);
			assign ax_w[t] = big ? axf_w[t][MW:1] : axf_w[t][MW-1:0];
			assign az_w[t] = big ? azf_w[t][MW:1] : azf_w[t][MW-1:0];
			assign sp_w[t] = big ? (sp_s1 >> 1) : sp_s1;
		end else begin : g_nored
			assign ax_w[t] = axf_w[t];
			assign az_w[t] = azf_w[t];
			assign sp_w[t] = sp_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int t = 0; t < 2; t++) begin
				ax_s2[t] <= ax_w[t];
				az_s2[t] <= az_w[t];
				sp_s2[t] <= sp_w[t];
				car_s2.nx[t] <= dx_s1[t][DW-1];
				car_s2.nz[t] <= dz_s1[t][DW-1];
			end
			car_s2.up <= (sp_s1 == '0);
			car_s2.ctr <= sum_s1[HB+1:2];
		end
	end

	// stage 3: squares
	logic [CW-1:0] sqx_s3 [2];
	logic [CW-1:0] sqz_s3 [2];
	logic [CW-1:0] sqs_s3 [2];
	carry_t car_s3;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int t = 0; t < 2; t++) begin
				sqx_s3[t] <= CW'(ax_s2[t]) * CW'(ax_s2[t]);
				sqz_s3[t] <= CW'(az_s2[t]) * CW'(az_s2[t]);
				sqs_s3[t] <= CW'(sp_s2[t]) * CW'(sp_s2[t]);
			end
			car_s3 <= car_s2;
		end
	end

	// stage 4: squared length per triangle, numerators per lane (x, y, z)
	logic [NW-1:0] n_s4 [2];
	logic [CW-1:0] num_s4 [6];
	carry_t car_s4;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			for (int t = 0; t < 2; t++) begin
				n_s4[t] <= NW'(sqx_s3[t]) + NW'(sqs_s3[t]) + NW'(sqz_s3[t]);
				num_s4[t*3] <= sqx_s3[t];
				num_s4[t*3+1] <= sqs_s3[t];
				num_s4[t*3+2] <= sqz_s3[t];
			end
			car_s4 <= car_s3;
		end
	end

	// restoring divide: D = floor(c^2 * 2^(2F+2) / n), one quotient bit per stage
	logic [NW-1:0] drem_s [QW][6];
	logic [QW-1:0] dquo_s [QW][6];
	logic [NW-1:0] dn_s [QW][2];
	carry_t dcar_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [NW-1:0] src_rem [6];
		logic src_bit [6];
		logic [QW-1:0] src_quo [6];
		logic [NW-1:0] src_n [2];
		carry_t src_car;
		logic [NW:0] tv [6];
		logic ge [6];

		if (k == 0) begin : g_first
			for (genvar l = 0; l < 6; l++) begin : g_l
				assign src_rem[l] = NW'(num_s4[l] >> 1);
				assign src_bit[l] = num_s4[l][0];
				assign src_quo[l] = '0;
			end
			assign src_n = n_s4;
			assign src_car = car_s4;
		end else begin : g_next
			for (genvar l = 0; l < 6; l++) begin : g_l
				assign src_rem[l] = drem_s[k-1][l];
				assign src_bit[l] = 1'b0;
				assign src_quo[l] = dquo_s[k-1][l];
			end
			assign src_n = dn_s[k-1];
			assign src_car = dcar_s[k-1];
		end

		always_comb begin
			for (int t = 0; t < 2; t++) begin
				for (int c = 0; c < 3; c++) begin
					tv[t*3+c] = {src_rem[t*3+c], src_bit[t*3+c]};
					ge[t*3+c] = tv[t*3+c] >= {1'b0, src_n[t]};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv[ST_DIV0+k]) begin
				for (int t = 0; t < 2; t++) begin
					for (int c = 0; c < 3; c++) begin
						drem_s[k][t*3+c] <= ge[t*3+c] ? NW'(tv[t*3+c] - {1'b0, src_n[t]})
							: NW'(tv[t*3+c]);
						dquo_s[k][t*3+c] <= {src_quo[t*3+c][QW-2:0], ge[t*3+c]};
					end
				end
				dn_s[k] <= src_n;
				dcar_s[k] <= src_car;
			end
		end
	end

	// square root of D, one root bit per stage
	logic [RW-1:0] sroot_s [RW][6];
	logic [QW-1:0] srem_s [RW][6];
	carry_t scar_s [RW];

	for (genvar j = 0; j < RW; j++) begin : g_sq
		localparam int B = RW - 1 - j;
		logic [RW-1:0] src_root [6];
		logic [QW-1:0] src_rem [6];
		carry_t src_car;
		logic [TW-1:0] trial [6];
		logic fit [6];

		if (j == 0) begin : g_first
			for (genvar l = 0; l < 6; l++) begin : g_l
				assign src_root[l] = '0;
				assign src_rem[l] = dquo_s[QW-1][l];
			end
			assign src_car = dcar_s[QW-1];
		end else begin : g_next
			for (genvar l = 0; l < 6; l++) begin : g_l
				assign src_root[l] = sroot_s[j-1][l];
				assign src_rem[l] = srem_s[j-1][l];
			end
			assign src_car = scar_s[j-1];
		end

		// (root + 2^b)^2 - root^2, with no carry between the two terms
		always_comb begin
			for (int l = 0; l < 6; l++) begin
				trial[l] = (TW'(src_root[l]) << (B + 1)) | (TW'(1) << (2 * B));
				fit[l] = TW'(src_rem[l]) >= trial[l];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[ST_SQ0+j]) begin
				for (int l = 0; l < 6; l++) begin
					srem_s[j][l] <= fit[l] ? QW'(TW'(src_rem[l]) - trial[l]) : src_rem[l];
					sroot_s[j][l] <= fit[l] ? (src_root[l] | (RW'(1) << B)) : src_root[l];
				end
				scar_s[j] <= src_car;
			end
		end
	end

	// output stage: q = (root + 1) / 2, then sign
	logic [RW-1:0] rp_w [6];
	logic [F:0] qv_w [6];
	logic signed [HB-1:0] ctr_so;
	logic signed [F+1:0] nx_so [2];
	logic signed [F+1:0] nz_so [2];
	logic [F:0] ny_so [2];
	carry_t fin_car;

	assign fin_car = scar_s[RW-1];
	for (genvar l = 0; l < 6; l++) begin : g_q
		assign rp_w[l] = sroot_s[RW-1][l] + RW'(1);
		assign qv_w[l] = rp_w[l][RW-1:1];
	end

	always_ff @(posedge clk) begin
		if (adv[ST_OUT]) begin
			ctr_so <= fin_car.ctr;
			for (int t = 0; t < 2; t++) begin
				if (fin_car.up) begin
					nx_so[t] <= '0;
					nz_so[t] <= '0;
					ny_so[t] <= Y_ONE;
				end else begin
					nx_so[t] <= fin_car.nx[t] ? -(F+2)'(qv_w[t*3]) : (F+2)'(qv_w[t*3]);
					ny_so[t] <= qv_w[t*3+1];
					nz_so[t] <= fin_car.nz[t] ? -(F+2)'(qv_w[t*3+2]) : (F+2)'(qv_w[t*3+2]);
				end
			end
		end
	end

	assign normals.valid = vld_s[L-1];
	assign normals.center_height = ctr_so;
	assign normals.upper_normal_x = nx_so[0];
	assign normals.upper_normal_y = ny_so[0];
	assign normals.upper_normal_z = nz_so[0];
	assign normals.lower_normal_x = nx_so[1];
	assign normals.lower_normal_y = ny_so[1];
	assign normals.lower_normal_z = nz_so[1];

	`TCN_ASSERT_IMP(a_ready_when_tail_free, !vld_s[L-1], cells.ready, "input stalled with free tail")
	`TCN_ASSERT_NXT(a_accept_fills_head, cells.valid && cells.ready, vld_s[0], "accepted word lost")
	`TCN_ASSERT_IMP(a_unit_y_bound, normals.valid, (normals.upper_normal_y <= Y_ONE) && (normals.lower_normal_y <= Y_ONE), "vertical component above one")

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import tcn_pkg::*;

	localparam int HB = HEIGHT_BITS;
	localparam int FB = NORMAL_FRAC_BITS;
	localparam int LATENCY = 3 * FB + 10;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 6000;

	typedef logic signed [HB-1:0] height_t;

	typedef struct {
		logic [HB-1:0] center;
		logic [FB+1:0] ux;
		logic [FB:0] uy;
		logic [FB+1:0] uz;
		logic [FB+1:0] lx;
		logic [FB:0] ly;
		logic [FB+1:0] lz;
	} cell_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [SPACING_BITS-1:0] cfg_wdata;
	int mismatches;
	int idle_cycles;
	bit long_hold_req;

	tcn_cell_if cell_bus ();
	tcn_norm_if norm_bus ();

	terrain_cell_normals_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.cells(cell_bus),
		.normals(norm_bus)
	);

	task automatic report(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// largest q in [0, 2^FB] with (2q-1)^2 * n <= 4 * c^2 * 2^(2FB)
	function automatic longint unsigned nearest_ratio(longint unsigned c, longint unsigned n);
		logic [127:0] rhs;
		logic [127:0] lhs;
		longint unsigned lo, hi, md, t;
		rhs = (128'(c) * c) << (2 * FB + 2);
		lo = 0;
		hi = 64'd1 << FB;
		while (lo < hi) begin
			md = lo + (hi - lo + 1) / 2;
			t = 2 * md - 1;
			lhs = 128'(t * t) * n;
			if (lhs <= rhs) lo = md;
			else hi = md - 1;
		end
		return lo;
	endfunction

	function automatic void face_normal(input longint dx, input longint unsigned spacing,
			input longint dz, output logic [FB+1:0] ox, output logic [FB:0] oy,
			output logic [FB+1:0] oz);
		longint unsigned ax, az, s, n, qx, qz;
		s = spacing;
		ax = (dx < 0) ? -dx : dx;
		az = (dz < 0) ? -dz : dz;
		while (ax >= (64'd1 << MAG_CAP_BITS) || az >= (64'd1 << MAG_CAP_BITS)) begin
			ax >>= 1;
			az >>= 1;
			s >>= 1;
		end
		n = ax * ax + s * s + az * az;
		if (s == 0 && n == 0 || spacing == 0) begin
			ox = '0;
			oy = (FB+1)'(64'd1 << FB);
			oz = '0;
		end else begin
			qx = nearest_ratio(ax, n);
			qz = nearest_ratio(az, n);
			ox = (dx < 0) ? (FB+2)'(-qx) : (FB+2)'(qx);
			oy = (FB+1)'(nearest_ratio(s, n));
			oz = (dz < 0) ? (FB+2)'(-qz) : (FB+2)'(qz);
		end
	endfunction

	class cell_scoreboard;
		logic [SPACING_BITS-1:0] spacing = SPACING_RESET;
		cell_result_t pending_results[int];
		int wr_count;
		int rd_count;

		function int outstanding();
			return wr_count - rd_count;
		endfunction

		function void note_cell(height_t h00, height_t h10, height_t h01, height_t h11);
			cell_result_t r;
			longint sum;
			sum = longint'(h00) + longint'(h10) + longint'(h01) + longint'(h11);
			r.center = HB'(sum >>> 2);
			face_normal(longint'(h00) - longint'(h10), spacing, longint'(h00) - longint'(h01),
				r.ux, r.uy, r.uz);
			face_normal(longint'(h01) - longint'(h11), spacing, longint'(h10) - longint'(h11),
				r.lx, r.ly, r.lz);
			pending_results[wr_count] = r;
			wr_count++;
		endfunction

		task check_result(cell_result_t got);
			cell_result_t exp;
			if (outstanding() == 0) begin
				report("result word with nothing expected");
				return;
			end
			exp = pending_results[rd_count];
			pending_results.delete(rd_count);
			rd_count++;
			if (got.center !== exp.center)
				report($sformatf("center_height got %0h exp %0h", got.center, exp.center));
			if (got.ux !== exp.ux)
				report($sformatf("upper_normal_x got %0h exp %0h", got.ux, exp.ux));
			if (got.uy !== exp.uy)
				report($sformatf("upper_normal_y got %0h exp %0h", got.uy, exp.uy));
			if (got.uz !== exp.uz)
				report($sformatf("upper_normal_z got %0h exp %0h", got.uz, exp.uz));
			if (got.lx !== exp.lx)
				report($sformatf("lower_normal_x got %0h exp %0h", got.lx, exp.lx));
			if (got.ly !== exp.ly)
				report($sformatf("lower_normal_y got %0h exp %0h", got.ly, exp.ly));
			if (got.lz !== exp.lz)
				report($sformatf("lower_normal_z got %0h exp %0h", got.lz, exp.lz));
		endtask
	endclass

	cell_scoreboard sb = new();

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cell_bus.valid = 1'b0;
		cell_bus.height_top_left = '0;
		cell_bus.height_top_right = '0;
		cell_bus.height_bottom_left = '0;
		cell_bus.height_bottom_right = '0;
		norm_bus.ready = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// receiver: random stalls, a few long ones, calm stretches, one long hold on request
	initial begin
		int r;
		int calm;
		calm = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				norm_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold_req = 1'b0;
			end else begin
				r = $urandom_range(0, 199);
				if (calm > 0) begin
					calm--;
					norm_bus.ready <= 1'b1;
				end else if (r < 3) begin
					calm = $urandom_range(20, 80);
					norm_bus.ready <= 1'b1;
				end else if (r < 5) begin
					norm_bus.ready <= 1'b0;
					repeat ($urandom_range(20, 60)) @(negedge clk);
				end else begin
					norm_bus.ready <= (r < 140);
				end
			end
		end
	end

	always @(posedge clk) begin
		cell_result_t got;
		if (arst_n && norm_bus.valid && norm_bus.ready) begin
			got.center = norm_bus.center_height;
			got.ux = norm_bus.upper_normal_x;
			got.uy = norm_bus.upper_normal_y;
			got.uz = norm_bus.upper_normal_z;
			got.lx = norm_bus.lower_normal_x;
			got.ly = norm_bus.lower_normal_y;
			got.lz = norm_bus.lower_normal_z;
			sb.check_result(got);
		end
	end

	always @(posedge clk) begin
		if ((cell_bus.valid && cell_bus.ready) || (norm_bus.valid && norm_bus.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_spacing(input logic [SPACING_BITS-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.spacing = value;
	endtask

	task automatic send_cell(input height_t h00, input height_t h10, input height_t h01,
			input height_t h11);
		@(negedge clk);
		cell_bus.valid <= 1'b1;
		cell_bus.height_top_left <= h00;
		cell_bus.height_top_right <= h10;
		cell_bus.height_bottom_left <= h01;
		cell_bus.height_bottom_right <= h11;
		do @(posedge clk); while (!cell_bus.ready);
		sb.note_cell(h00, h10, h01, h11);
	endtask

	task automatic sender_gap();
		int r;
		int len;
		r = $urandom_range(0, 99);
		if (r < 65) return;
		len = (r < 97) ? $urandom_range(1, 3) : $urandom_range(15, 50);
		@(negedge clk);
		cell_bus.valid <= 1'b0;
		repeat (len - 1) @(negedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		cell_bus.valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	function automatic height_t rand_height();
		return height_t'($urandom);
	endfunction

	task automatic random_cells(input int count, input bit gaps);
		height_t base;
		int mode;
		int spread;
		for (int i = 0; i < count; i++) begin
			mode = $urandom_range(0, 9);
			base = rand_height();
			spread = (mode < 5) ? 64 : 4096;
			if (mode < 8)
				// terrain-like: corners close to a common height
				send_cell(base + height_t'($urandom_range(0, 2 * spread) - spread),
					base + height_t'($urandom_range(0, 2 * spread) - spread),
					base + height_t'($urandom_range(0, 2 * spread) - spread),
					base + height_t'($urandom_range(0, 2 * spread) - spread));
			else
				send_cell(rand_height(), rand_height(), rand_height(), rand_height());
			if (gaps) sender_gap();
		end
	endtask

	initial begin
		height_t hmax, hmin;
		logic [SPACING_BITS-1:0] phase_spacing [6];
		mismatches = 0;
		idle_cycles = 0;
		long_hold_req = 1'b0;
		hmax = height_t'(2 ** (HB - 1) - 1);
		hmin = height_t'(-(2 ** (HB - 1)));
		wait (arst_n === 1'b1);

		// directed corners at reset spacing, then spacing extremes
		send_cell(0, 0, 0, 0);
		send_cell(hmax, hmax, hmax, hmax);
		send_cell(hmin, hmin, hmin, hmin);
		send_cell(hmax, hmin, hmin, hmax);
		send_cell(hmin, hmax, hmax, hmin);
		send_cell(-1, 0, 0, 0);
		send_cell(-1, -1, -1, 0);
		send_cell(1, 2, 3, 5);
		send_cell(8, 0, 0, 8);
		send_cell(0, 8, 8, 0);
		send_cell(hmax, hmin, hmax, hmin);
		send_cell(-3, 5, -7, 11);
		drain();
		write_spacing(8'd255);
		send_cell(hmax, hmin, hmin, hmax);
		send_cell(0, 255, 255, 0);
		send_cell(1, 0, 0, 1);
		drain();
		write_spacing(8'd1);
		send_cell(hmax, hmin, hmin, hmax);
		send_cell(0, 1, 1, 0);
		send_cell(1, 0, 0, 0);
		drain();
		write_spacing(8'd0);
		send_cell(hmax, hmin, 7, -9);
		send_cell(0, 0, 0, 0);
		random_cells(60, 1'b1);
		drain();

		phase_spacing[0] = 8'd8;
		phase_spacing[1] = 8'd255;
		phase_spacing[2] = 8'd1;
		phase_spacing[3] = SPACING_BITS'($urandom_range(2, 254));
		phase_spacing[4] = SPACING_BITS'($urandom_range(2, 254));
		phase_spacing[5] = 8'd16;
		foreach (phase_spacing[p]) begin
			write_spacing(phase_spacing[p]);
			// back-to-back words into a held-off receiver fill the pipeline
			if (p == 1) begin
				long_hold_req = 1'b1;
				random_cells(120, 1'b0);
			end
			random_cells(290, 1'b1);
			drain();
		end

		@(negedge clk);
		cell_bus.valid <= 1'b0;
		drain();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
